// ===== rtl/fixed_slot_string_table_macros.svh =====
// Assertion macros used by the checker file.
`ifndef FIXED_SLOT_STRING_TABLE_MACROS_SVH
`define FIXED_SLOT_STRING_TABLE_MACROS_SVH

// Clocked assertion, quiet while reset is held.
`define FSST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define FSST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/fsst_pkg.sv =====
// ----------------------------------------------------------------------------
// fsst_pkg
// Types, constants and helper functions for the fixed slot string table.
// ----------------------------------------------------------------------------
package fsst_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int SLOT_BYTES  = 64;
  localparam int ROW_W       = SLOT_BYTES * 8;
  localparam int LEN_W       = 6;
  localparam int SW_W        = 7;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_SET    = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_FIND   = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_WRITE,
    S_SCAN,
    S_READ,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [8:0]  position;
    logic [8:0]  range_end;
    logic [5:0]  length;
    logic [63:0] text_0;
    logic [63:0] text_1;
    logic [63:0] text_2;
    logic [63:0] text_3;
    logic [63:0] text_4;
    logic [63:0] text_5;
    logic [63:0] text_6;
    logic [63:0] text_7;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [7:0]  match_index;
    logic [8:0]  entry_total;
    logic [63:0] read_0;
    logic [63:0] read_1;
    logic [63:0] read_2;
    logic [63:0] read_3;
    logic [63:0] read_4;
    logic [63:0] read_5;
    logic [63:0] read_6;
    logic [63:0] read_7;
  } out_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ROW_W-1:0]  wr_data;
  } ram_req_t;

  // Keep the first n bytes of a row.
  function automatic logic [ROW_W-1:0] byte_mask(input logic [SW_W-1:0] n);
    logic [ROW_W-1:0] m;
    m = '0;
    for (int b = 0; b < SLOT_BYTES; b++) begin
      m[b*8 +: 8] = (SW_W'(b) < n) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

  // Slot width needed for a string length.
  function automatic logic [SW_W-1:0] width_for(input logic [LEN_W-1:0] len);
    logic [SW_W-1:0] w;
    if (len[5])      w = SW_W'(64);
    else if (len[4]) w = SW_W'(32);
    else if (len[3]) w = SW_W'(16);
    else if (len[2]) w = SW_W'(8);
    else if (len != '0) w = SW_W'(4);
    else             w = '0;
    return w;
  endfunction

endpackage

// ===== rtl/fsst_ram.sv =====
// ----------------------------------------------------------------------------
// fsst_ram
// Row store: one full slot per row, one write and one registered read port.
// ----------------------------------------------------------------------------
module fsst_ram (
  input  logic                           clk,
  input  fsst_pkg::ram_req_t             req,
  output logic [fsst_pkg::ROW_W-1:0]     rdata
);

  logic [fsst_pkg::ROW_W-1:0] mem [fsst_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rdata <= mem[req.rd_addr];
    end
  end

endmodule

// ===== rtl/fsst_ctrl.sv =====
// ----------------------------------------------------------------------------
// fsst_ctrl
// Sequencer: moves, scans and compares one row per cycle through the store.
// ----------------------------------------------------------------------------
module fsst_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  fsst_pkg::in_t               in_data,
  input  logic                        res_free,
  output logic                        res_valid,
  output fsst_pkg::out_t              res_data,
  output fsst_pkg::ram_req_t          ram_req,
  input  logic [fsst_pkg::ROW_W-1:0]  ram_rdata
);

  fsst_pkg::state_t state_r, state_nxt;
  logic [fsst_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [fsst_pkg::SW_W-1:0]  slot_w_r, slot_w_nxt;
  logic [fsst_pkg::CNT_W-1:0] idx_r, idx_nxt;
  logic [fsst_pkg::CNT_W-1:0] pos_r, pos_nxt;
  logic [fsst_pkg::CNT_W-1:0] end_r, end_nxt;
  logic [fsst_pkg::LEN_W-1:0] len_r, len_nxt;
  logic [fsst_pkg::ROW_W-1:0] key_r, key_nxt;
  logic [1:0]                 status_r, status_nxt;
  logic                       found_r, found_nxt;
  logic [7:0]                 match_r, match_nxt;
  logic [fsst_pkg::ROW_W-1:0] read_r, read_nxt;
  logic                       ins_r, ins_nxt;

  logic [fsst_pkg::ROW_W-1:0] in_key;
  logic [fsst_pkg::CNT_W-1:0] find_end;
  logic                       row_match;

  assign in_key = {in_data.text_7, in_data.text_6, in_data.text_5, in_data.text_4,
                   in_data.text_3, in_data.text_2, in_data.text_1, in_data.text_0}
                  & fsst_pkg::byte_mask({1'b0, in_data.length});
  assign find_end = (in_data.range_end < cnt_r) ? in_data.range_end : cnt_r;
  // Entry matches when its first length+1 bytes equal the zero-padded key.
  assign row_match = ((ram_rdata & fsst_pkg::byte_mask(fsst_pkg::SW_W'(len_r) + 1'b1))
                      == key_r);

  assign in_stall = (state_r != fsst_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= fsst_pkg::S_IDLE;
      cnt_r    <= '0;
      slot_w_r <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      slot_w_r <= slot_w_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    end_r    <= end_nxt;
    len_r    <= len_nxt;
    key_r    <= key_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
    match_r  <= match_nxt;
    read_r   <= read_nxt;
    ins_r    <= ins_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    slot_w_nxt = slot_w_r;
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    end_nxt    = end_r;
    len_nxt    = len_r;
    key_nxt    = key_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    match_nxt  = match_r;
    read_nxt   = read_r;
    ins_nxt    = ins_r;
    ram_req    = '0;
    res_valid  = 1'b0;

    case (state_r)
      fsst_pkg::S_IDLE: begin
        if (in_valid) begin
          pos_nxt    = in_data.position;
          len_nxt    = in_data.length;
          key_nxt    = in_key;
          ins_nxt    = (in_data.op == fsst_pkg::OP_INSERT);
          status_nxt = fsst_pkg::ST_OK;
          found_nxt  = 1'b0;
          match_nxt  = '0;
          read_nxt   = '0;
          state_nxt  = fsst_pkg::S_DONE;
          case (in_data.op)
            fsst_pkg::OP_INSERT: begin
              if (cnt_r == fsst_pkg::CNT_W'(fsst_pkg::TABLE_DEPTH)) begin
                status_nxt = fsst_pkg::ST_FULL;
              end else if (in_data.position > cnt_r) begin
                status_nxt = fsst_pkg::ST_RANGE;
              end else if (in_data.position == cnt_r) begin
                state_nxt = fsst_pkg::S_WRITE;
              end else begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = fsst_pkg::ADDR_W'(cnt_r - 1'b1);
                idx_nxt         = cnt_r;
                state_nxt       = fsst_pkg::S_SHIFT_UP;
              end
            end
            fsst_pkg::OP_SET: begin
              if (in_data.position >= cnt_r) begin
                status_nxt = fsst_pkg::ST_RANGE;
              end else begin
                state_nxt = fsst_pkg::S_WRITE;
              end
            end
            fsst_pkg::OP_DELETE: begin
              if (in_data.position >= cnt_r) begin
                status_nxt = fsst_pkg::ST_RANGE;
              end else if (in_data.position == cnt_r - 1'b1) begin
                cnt_nxt = cnt_r - 1'b1;
              end else begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = fsst_pkg::ADDR_W'(in_data.position + 1'b1);
                idx_nxt         = in_data.position;
                state_nxt       = fsst_pkg::S_SHIFT_DN;
              end
            end
            fsst_pkg::OP_FIND: begin
              if (in_data.position > find_end) begin
                status_nxt = fsst_pkg::ST_RANGE;
              end else if (in_data.position != find_end) begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = in_data.position[fsst_pkg::ADDR_W-1:0];
                idx_nxt         = in_data.position;
                end_nxt         = find_end;
                state_nxt       = fsst_pkg::S_SCAN;
              end
            end
            fsst_pkg::OP_READ: begin
              if (in_data.position >= cnt_r) begin
                status_nxt = fsst_pkg::ST_RANGE;
              end else begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = in_data.position[fsst_pkg::ADDR_W-1:0];
                state_nxt       = fsst_pkg::S_READ;
              end
            end
            default: begin
              status_nxt = fsst_pkg::ST_OK;
            end
          endcase
        end
      end

      fsst_pkg::S_SHIFT_UP: begin
        // Row idx-1 arrived last cycle: drop it into row idx.
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = idx_r[fsst_pkg::ADDR_W-1:0];
        ram_req.wr_data = ram_rdata;
        idx_nxt         = idx_r - 1'b1;
        if (idx_r > pos_r + 1'b1) begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = fsst_pkg::ADDR_W'(idx_r - 2'd2);
        end else begin
          state_nxt = fsst_pkg::S_WRITE;
        end
      end

      fsst_pkg::S_SHIFT_DN: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = idx_r[fsst_pkg::ADDR_W-1:0];
        ram_req.wr_data = ram_rdata;
        idx_nxt         = idx_r + 1'b1;
        if (idx_r + 2'd2 < cnt_r) begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = fsst_pkg::ADDR_W'(idx_r + 2'd2);
        end else begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = fsst_pkg::S_DONE;
        end
      end

      fsst_pkg::S_WRITE: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = pos_r[fsst_pkg::ADDR_W-1:0];
        ram_req.wr_data = key_r;
        // Insert grows the table once its row is written.
        if (ins_r) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (fsst_pkg::width_for(len_r) > slot_w_r) begin
          slot_w_nxt = fsst_pkg::width_for(len_r);
        end
        state_nxt = fsst_pkg::S_DONE;
      end

      fsst_pkg::S_SCAN: begin
        if (row_match) begin
          found_nxt = 1'b1;
          match_nxt = idx_r[7:0];
          state_nxt = fsst_pkg::S_DONE;
        end else if (idx_r + 1'b1 < end_r) begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = fsst_pkg::ADDR_W'(idx_r + 1'b1);
          idx_nxt         = idx_r + 1'b1;
        end else begin
          state_nxt = fsst_pkg::S_DONE;
        end
      end

      fsst_pkg::S_READ: begin
        read_nxt  = ram_rdata;
        state_nxt = fsst_pkg::S_DONE;
      end

      fsst_pkg::S_DONE: begin
        if (res_free) begin
          res_valid = 1'b1;
          state_nxt = fsst_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = fsst_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_data             = '0;
    res_data.status      = status_r;
    res_data.found       = found_r;
    res_data.match_index = match_r;
    res_data.entry_total = cnt_r;
    res_data.read_0      = read_r[0*64 +: 64];
    res_data.read_1      = read_r[1*64 +: 64];
    res_data.read_2      = read_r[2*64 +: 64];
    res_data.read_3      = read_r[3*64 +: 64];
    res_data.read_4      = read_r[4*64 +: 64];
    res_data.read_5      = read_r[5*64 +: 64];
    res_data.read_6      = read_r[6*64 +: 64];
    res_data.read_7      = read_r[7*64 +: 64];
  end

endmodule

// ===== rtl/fixed_slot_string_table.sv =====
// ----------------------------------------------------------------------------
// fixed_slot_string_table
// Ordered table of up to 256 strings of up to 63 bytes, one slot per entry.
// ----------------------------------------------------------------------------
// Each input transaction is one operation (insert, set, delete, find first,
// read) and yields exactly one result transaction. The store holds one full
// 64-byte slot per row, and a small sequencer walks it one row per cycle
// through a single read and a single write port, then hands the result to
// the output register. in_stall is high while an operation is in flight;
// the output register lets a new transaction be accepted while the last
// result still waits for out_stall to drop. The store needs no clearing
// after reset: only rows below the entry count are ever read.
module fixed_slot_string_table (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  fsst_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output fsst_pkg::out_t  out_data
);

  fsst_pkg::ram_req_t          ram_req;
  logic [fsst_pkg::ROW_W-1:0]  ram_rdata;
  logic                        res_valid;
  fsst_pkg::out_t              res_data;
  logic                        res_free;

  logic                        out_valid_r, out_valid_nxt;
  fsst_pkg::out_t              out_data_r;

  fsst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .res_free  (res_free),
    .res_valid (res_valid),
    .res_data  (res_data),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  fsst_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  // Output slot frees when empty or when its transaction completes this edge.
  assign res_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the payload until taken.
  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/fsst_chk.sv =====
// ----------------------------------------------------------------------------
// fsst_chk
// Port-level checks on the result channel of the string table.
// ----------------------------------------------------------------------------
`include "fixed_slot_string_table_macros.svh"

module fsst_chk (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_stall,
  input fsst_pkg::out_t  out_data
);

  `FSST_ASSERT(a_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "result dropped while stalled")
  `FSST_ASSERT(a_err_nofind, out_valid && out_data.status != fsst_pkg::ST_OK |-> !out_data.found, "error result reports a match")
  `FSST_ASSERT(a_match_in_table, out_valid && out_data.found |-> {1'b0, out_data.match_index} < out_data.entry_total, "match beyond entry count")
  `FSST_ASSERT(a_total_cap, out_valid |-> out_data.entry_total <= 9'd256, "entry count above depth")
  `FSST_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind fixed_slot_string_table fsst_chk u_fsst_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/fixed_slot_string_table_tb.sv =====
// ----------------------------------------------------------------------------
// fixed_slot_string_table_tb
// Self-checking bench for the fixed slot string table.
// ----------------------------------------------------------------------------
// Drives insert, set, delete, find and read operations through the valid/stall
// input channel, predicts each result from a private copy of the table and
// compares every accepted result field by field, oldest first.
// ----------------------------------------------------------------------------
module fixed_slot_string_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IN_W = $bits(fsst_pkg::in_t);

  // Table shadow plus queue of predicted results.
  class table_scoreboard;
    logic [fsst_pkg::ROW_W-1:0] rows [fsst_pkg::TABLE_DEPTH];
    int                         count;
    fsst_pkg::out_t             pending [$];
    int                         errors;

    function void clear();
      count = 0;
      errors = 0;
      pending.delete();
      foreach (rows[i]) rows[i] = '0;
    endfunction

    function void note_input(fsst_pkg::in_t t);
      fsst_pkg::out_t             r;
      logic [fsst_pkg::ROW_W-1:0] key;
      logic [fsst_pkg::ROW_W-1:0] m;
      int                         stop;
      r = '0;
      key = {t.text_7, t.text_6, t.text_5, t.text_4,
             t.text_3, t.text_2, t.text_1, t.text_0};
      m = '0;
      for (int b = 0; b < fsst_pkg::SLOT_BYTES; b++) if (b < t.length) m[b*8 +: 8] = 8'hFF;
      key = key & m;
      case (t.op)
        fsst_pkg::OP_INSERT: begin
          if (count >= fsst_pkg::TABLE_DEPTH) r.status = fsst_pkg::ST_FULL;
          else if (t.position > count) r.status = fsst_pkg::ST_RANGE;
          else begin
            for (int i = count; i > t.position; i--) rows[i] = rows[i-1];
            rows[t.position] = key;
            count++;
          end
        end
        fsst_pkg::OP_SET: begin
          if (t.position >= count) r.status = fsst_pkg::ST_RANGE;
          else rows[t.position] = key;
        end
        fsst_pkg::OP_DELETE: begin
          if (t.position >= count) r.status = fsst_pkg::ST_RANGE;
          else begin
            for (int i = t.position; i < count - 1; i++) rows[i] = rows[i+1];
            count--;
          end
        end
        fsst_pkg::OP_FIND: begin
          stop = (t.range_end < count) ? t.range_end : count;
          if (t.position > stop) r.status = fsst_pkg::ST_RANGE;
          else begin
            // Compare length bytes plus the terminating zero byte.
            for (int b = 0; b < fsst_pkg::SLOT_BYTES; b++) if (b <= t.length) m[b*8 +: 8] = 8'hFF;
            for (int i = t.position; i < stop; i++) begin
              if ((rows[i] & m) == key) begin
                r.found = 1'b1;
                r.match_index = i[7:0];
                break;
              end
            end
          end
        end
        fsst_pkg::OP_READ: begin
          if (t.position >= count) r.status = fsst_pkg::ST_RANGE;
          else {r.read_7, r.read_6, r.read_5, r.read_4,
                r.read_3, r.read_2, r.read_1, r.read_0} = rows[t.position];
        end
        default: ;
      endcase
      r.entry_total = count[8:0];
      pending.push_back(r);
    endfunction

    function void check_result(fsst_pkg::out_t got);
      fsst_pkg::out_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) begin
        $display("%0t: status exp %0d got %0d", $realtime, e.status, got.status);
        errors++;
      end
      if (got.found !== e.found) begin
        $display("%0t: found exp %0d got %0d", $realtime, e.found, got.found);
        errors++;
      end
      if (got.match_index !== e.match_index) begin
        $display("%0t: match_index exp %0d got %0d", $realtime, e.match_index,
                 got.match_index);
        errors++;
      end
      if (got.entry_total !== e.entry_total) begin
        $display("%0t: entry_total exp %0d got %0d", $realtime, e.entry_total,
                 got.entry_total);
        errors++;
      end
      if ({got.read_7, got.read_6, got.read_5, got.read_4,
           got.read_3, got.read_2, got.read_1, got.read_0} !==
          {e.read_7, e.read_6, e.read_5, e.read_4,
           e.read_3, e.read_2, e.read_1, e.read_0}) begin
        $display("%0t: read data exp %h got %h", $realtime,
                 {e.read_7, e.read_6, e.read_5, e.read_4,
                  e.read_3, e.read_2, e.read_1, e.read_0},
                 {got.read_7, got.read_6, got.read_5, got.read_4,
                  got.read_3, got.read_2, got.read_1, got.read_0});
        errors++;
      end
    endfunction
  endclass

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  fsst_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_stall;
  fsst_pkg::out_t out_data;

  table_scoreboard sb;

  // Idle controls: quiet_idle disables random gaps and stalls, hold_off_cycles
  // parks the receiver for a long stretch.
  bit quiet_idle;
  int hold_off_cycles;

  fixed_slot_string_table u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous limit on run time, allowing for stalls.
  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Check every accepted result transaction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Receiver: random stall, with a long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      out_stall <= 1'b1;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_stall <= !quiet_idle && ($urandom_range(99) < 9);
    end
  end

  // Fully random input payload.
  function automatic fsst_pkg::in_t rand_in();
    logic [17*32-1:0] v;
    for (int w = 0; w < 17; w++) v[w*32 +: 32] = $urandom;
    return fsst_pkg::in_t'(v[IN_W-1:0]);
  endfunction

  // Offer a transaction, hold it until accepted, then idle for random gaps.
  task automatic send_item(fsst_pkg::in_t t);
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
    sb.note_input(t);
    while (!quiet_idle && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      in_data  <= rand_in();
      @(posedge clk);
    end
  endtask

  // Drop valid and wait for every outstanding result.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Build an item; text bytes are random, with random junk past length.
  function automatic fsst_pkg::in_t make_item(logic [2:0] op, int pos, int rend, int len);
    fsst_pkg::in_t t;
    t = rand_in();
    t.op = op;
    t.position = pos[8:0];
    t.range_end = rend[8:0];
    t.length = len[5:0];
    return t;
  endfunction

  // Copy a stored row into the text of an item, so finds can hit.
  function automatic fsst_pkg::in_t with_row(fsst_pkg::in_t t, int idx, int len);
    logic [fsst_pkg::ROW_W-1:0] r;
    r = sb.rows[idx];
    {t.text_7, t.text_6, t.text_5, t.text_4,
     t.text_3, t.text_2, t.text_1, t.text_0} = r;
    t.length = len[5:0];
    return t;
  endfunction

  // Small alphabet strings make duplicates and near matches common.
  function automatic fsst_pkg::in_t short_text(fsst_pkg::in_t t);
    for (int b = 0; b < 8; b++) t.text_0[b*8 +: 8] = 8'(8'h61 + $urandom_range(2));
    t.length = 6'($urandom_range(4));
    return t;
  endfunction

  task automatic random_item();
    fsst_pkg::in_t t;
    int            n;
    int            k;
    int            pos;
    int            len;
    n = sb.count;
    k = $urandom_range(99);
    len = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(8);
    pos = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(n);
    if (k < 35 && n < fsst_pkg::TABLE_DEPTH)
      t = make_item(fsst_pkg::OP_INSERT, pos, 0, len);
    else if (k < 45)
      t = make_item(fsst_pkg::OP_SET, pos, 0, len);
    else if (k < 65)
      t = make_item(fsst_pkg::OP_DELETE, pos, 0, len);
    else if (k < 85) begin
      t = make_item(fsst_pkg::OP_FIND, $urandom_range(n), $urandom_range(n + 4), len);
      if ($urandom_range(9) == 0) t.position = 9'($urandom_range(511));
      if ($urandom_range(9) == 0) t.range_end = 9'($urandom_range(511));
      if (n > 0 && $urandom_range(1)) begin
        pos = $urandom_range(n - 1);
        t = with_row(t, pos, $urandom_range(63));
      end
    end else if (k < 97)
      t = make_item(fsst_pkg::OP_READ, pos, 0, len);
    else
      t = make_item(3'(5 + $urandom_range(2)), pos, $urandom_range(511), len);
    if ($urandom_range(2) == 0 && t.op != fsst_pkg::OP_READ) t = short_text(t);
    send_item(t);
  endtask

  initial begin
    fsst_pkg::in_t t;
    sb = new();
    sb.clear();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    quiet_idle = 1'b0;
    hold_off_cycles = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: errors on an empty table, unknown ops, extremes of length.
    send_item(make_item(fsst_pkg::OP_READ, 0, 0, 0));
    send_item(make_item(fsst_pkg::OP_DELETE, 511, 0, 0));
    send_item(make_item(fsst_pkg::OP_SET, 0, 0, 5));
    send_item(make_item(fsst_pkg::OP_INSERT, 1, 0, 3));
    send_item(make_item(fsst_pkg::OP_FIND, 0, 0, 0));
    send_item(make_item(fsst_pkg::OP_FIND, 1, 511, 0));
    send_item(make_item(3'd7, 511, 511, 63));
    t = make_item(fsst_pkg::OP_INSERT, 0, 0, 0);
    send_item(t);
    t = make_item(fsst_pkg::OP_INSERT, 1, 0, 63);
    t.text_7 = '1;
    send_item(t);
    t = make_item(fsst_pkg::OP_INSERT, 0, 0, 7);
    t.text_0[23:16] = 8'h00;
    send_item(t);
    send_item(with_row(make_item(fsst_pkg::OP_FIND, 0, 511, 0), 2, 63));
    send_item(make_item(fsst_pkg::OP_FIND, 0, 3, 0));
    send_item(with_row(make_item(fsst_pkg::OP_FIND, 0, 511, 0), 0, 7));
    send_item(with_row(make_item(fsst_pkg::OP_FIND, 0, 511, 0), 0, 6));
    send_item(make_item(fsst_pkg::OP_FIND, 3, 3, 2));
    send_item(make_item(fsst_pkg::OP_SET, 2, 0, 1));
    send_item(make_item(fsst_pkg::OP_READ, 2, 0, 0));
    send_item(make_item(fsst_pkg::OP_READ, 0, 0, 0));
    send_item(make_item(fsst_pkg::OP_DELETE, 0, 0, 0));
    send_item(make_item(fsst_pkg::OP_READ, 2, 0, 0));

    // Long receiver hold-off while the sender keeps offering.
    hold_off_cycles <= 400;
    repeat (12) random_item();
    drain();

    // Fill the table, probe insert, find and read when full, delete the last.
    while (sb.count < fsst_pkg::TABLE_DEPTH) begin
      if ($urandom_range(15) == 0) random_item();
      else send_item(make_item(fsst_pkg::OP_INSERT, $urandom_range(sb.count), 0,
                               $urandom_range(63)));
    end
    send_item(make_item(fsst_pkg::OP_INSERT, 0, 0, 4));
    send_item(make_item(fsst_pkg::OP_INSERT, 256, 0, 4));
    send_item(with_row(make_item(fsst_pkg::OP_FIND, 0, 511, 0), 255, 63));
    send_item(make_item(fsst_pkg::OP_READ, 255, 0, 0));
    send_item(make_item(fsst_pkg::OP_DELETE, 255, 0, 0));

    // Random body; one stretch without any idling.
    for (int i = 0; i < 1300; i++) begin
      quiet_idle = (i >= 400 && i < 600);
      random_item();
      if (i == 800) drain();
    end
    quiet_idle = 1'b0;
    while (sb.count > 0)
      send_item(make_item(fsst_pkg::OP_DELETE, $urandom_range(sb.count - 1), 0, 0));

    drain();
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== fixed_slot_string_table.f =====
+incdir+rtl
rtl/fsst_pkg.sv
rtl/fsst_ram.sv
rtl/fsst_ctrl.sv
rtl/fixed_slot_string_table.sv
rtl/fsst_chk.sv
tb/fixed_slot_string_table_tb.sv
